@@ sv/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int PRI_W    = 16;  // priority field width
    localparam int FIELD_W  = 32;  // value field width on the ports
    localparam int COUNT_W  = 5;   // entry count field width on the ports
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_status                   status;
        logic [FIELD_W-1:0]        removed_value;
        logic signed [PRI_W-1:0]   removed_priority;
        logic [FIELD_W-1:0]        front_value;
        logic signed [PRI_W-1:0]   front_priority;
        logic                      queue_empty;
        logic [COUNT_W-1:0]        entry_count;
    } t_result;

endpackage

@@ sv/stable_priority_queue.sv @@
// Top level of the stable priority queue: sequencer, entry RAM and output register.
// An insert walks tail to head with one compare per cycle, past every entry with a
// strictly larger priority. An insert into an empty queue, a refused insert, a remove on
// empty and a remove that empties the queue go straight to the emit state; any other
// remove first reloads the front from RAM. One word in flight. Reset clears count.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // command channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_opcode,
    input  logic [FIELD_W-1:0]      i_item_value,
    input  logic signed [PRI_W-1:0] i_item_priority,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [STATUS_W-1:0]     o_status,
    output logic [FIELD_W-1:0]      o_removed_value,
    output logic signed [PRI_W-1:0] o_removed_priority,
    output logic [FIELD_W-1:0]      o_front_value,
    output logic signed [PRI_W-1:0] o_front_priority,
    output logic                    o_queue_empty,
    output logic [COUNT_W-1:0]      o_entry_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int ENT_W = VALUE_WIDTH + PRI_W;

    logic              seq_idle;
    logic              seq_res_valid;
    t_result           seq_res;
    logic              out_free;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    logic              r_out_valid;
    t_result           r_out;

    // The sequencer takes one word at a time; it is ready only between operations.
    assign o_in_ready = seq_idle;
    // The output register frees up in the same cycle its word is taken.
    assign out_free   = !r_out_valid || i_out_ready;

    spq_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && seq_idle),
        .i_opcode    (i_opcode),
        .i_value     (VALUE_WIDTH'(i_item_value)),
        .i_priority  (i_item_priority),
        .o_idle      (seq_idle),
        .i_out_free  (out_free),
        .o_res_valid (seq_res_valid),
        .o_res       (seq_res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Sorted entries live in a ring: logical slot 0 is the front at the head pointer.
    spq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Hold the result word until taken; load a new one when the sequencer emits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (seq_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (seq_res_valid) begin
            r_out <= seq_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out.status;
    assign o_removed_value    = r_out.removed_value;
    assign o_removed_priority = r_out.removed_priority;
    assign o_front_value      = r_out.front_value;
    assign o_front_priority   = r_out.front_priority;
    assign o_queue_empty      = r_out.queue_empty;
    assign o_entry_count      = r_out.entry_count;

    // A refused insert reports a full queue.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_entry_count == COUNT_W'(CAPACITY)))
        else $error("full status without a full count");

    // An empty flag comes with a zero count and a zero front.
    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_queue_empty) |->
            (o_entry_count == '0 && o_front_value == '0 && o_front_priority == '0))
        else $error("empty queue reports entries or a front");

    // A remove on an empty queue leaves it empty.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> o_queue_empty)
        else $error("empty status on a non-empty queue");

    // An accepted word moves the sequencer out of idle, which drops ready.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after an accepted word");

endmodule

@@ sv/spq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/spq_seq.sv @@
// Sequencer: ring-buffer pointers, tail-to-head insert walk with one shared compare.
module spq_seq
    import spq_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IDX_W      = $clog2(CAPACITY),
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int ENT_W      = VALUE_WIDTH + PRI_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // command
    input  logic                    i_start,
    input  logic                    i_opcode,
    input  logic [VALUE_WIDTH-1:0]  i_value,
    input  logic signed [PRI_W-1:0] i_priority,
    output logic                    o_idle,
    // result
    input  logic                    i_out_free,
    output logic                    o_res_valid,
    output t_result                 o_res,
    // entry store
    output logic                    o_ram_we,
    output logic [IDX_W-1:0]        o_ram_waddr,
    output logic [ENT_W-1:0]        o_ram_wdata,
    output logic [IDX_W-1:0]        o_ram_raddr,
    input  logic [ENT_W-1:0]        i_ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT0,
        S_REM_RD,
        S_REM_LD,
        S_EMIT
    } t_state;

    localparam logic [IDX_W:0] CAP_L = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    t_state                   r_state;
    logic [IDX_W-1:0]         r_head;
    logic [CNT_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_idx;
    logic [VALUE_WIDTH-1:0]   r_new_val;
    logic signed [PRI_W-1:0]  r_new_pri;
    logic [VALUE_WIDTH-1:0]   r_front_val;
    logic signed [PRI_W-1:0]  r_front_pri;
    logic [VALUE_WIDTH-1:0]   r_rem_val;
    logic signed [PRI_W-1:0]  r_rem_pri;
    t_status                  r_status;

    logic [VALUE_WIDTH-1:0]   rd_val;
    logic signed [PRI_W-1:0]  rd_pri;
    logic                     rd_later;
    logic [IDX_W-1:0]         rd_off;
    logic [IDX_W-1:0]         wr_off;
    logic [IDX_W-1:0]         head_next;

    // Physical slot of a logical position: head plus offset, wrapped at CAPACITY.
    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= CAP_L) begin
            sum = sum - CAP_L;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign rd_val   = i_ram_rdata[ENT_W-1:PRI_W];
    assign rd_pri   = i_ram_rdata[PRI_W-1:0];
    // Shared compare: held entry goes behind the new one only if strictly larger.
    assign rd_later = rd_pri > r_new_pri;

    assign head_next = wrap(r_head, IDX_W'(1));

    always_comb begin
        rd_off      = '0;
        wr_off      = '0;
        o_ram_we    = 1'b0;
        o_ram_wdata = {r_new_val, r_new_pri};
        case (r_state)
            S_IDLE: begin
                o_ram_wdata = {i_value, i_priority};
                o_ram_we    = i_start && (i_opcode == OP_INSERT) && (r_count == '0);
            end
            S_INS_RD: begin
                rd_off = r_idx;
            end
            S_INS_CMP: begin
                rd_off   = r_idx - IDX_W'(1);
                wr_off   = r_idx + IDX_W'(1);
                o_ram_we = 1'b1;
                if (rd_later) begin
                    o_ram_wdata = i_ram_rdata;
                end
            end
            S_INS_PUT0: begin
                o_ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_ram_raddr = wrap(r_head, rd_off);
    assign o_ram_waddr = wrap(r_head, wr_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_front_val <= '0;
            r_front_pri <= '0;
            r_status    <= ST_DONE;
            r_rem_val   <= '0;
            r_rem_pri   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_new_val <= i_value;
                        r_new_pri <= i_priority;
                        if (i_opcode == OP_INSERT) begin
                            r_rem_val <= '0;
                            r_rem_pri <= '0;
                            if (r_count == CAP_CNT) begin
                                r_status <= ST_FULL;
                                r_state  <= S_EMIT;
                            end else if (r_count == '0) begin
                                r_status    <= ST_DONE;
                                r_front_val <= i_value;
                                r_front_pri <= i_priority;
                                r_count     <= r_count + CNT_W'(1);
                                r_state     <= S_EMIT;
                            end else begin
                                r_status <= ST_DONE;
                                r_idx    <= IDX_W'(r_count - CNT_W'(1));
                                r_state  <= S_INS_RD;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_status  <= ST_EMPTY;
                                r_rem_val <= '0;
                                r_rem_pri <= '0;
                                r_state   <= S_EMIT;
                            end else begin
                                r_status  <= ST_DONE;
                                r_rem_val <= r_front_val;
                                r_rem_pri <= r_front_pri;
                                r_head    <= head_next;
                                r_count   <= r_count - CNT_W'(1);
                                if (r_count == CNT_W'(1)) begin
                                    r_front_val <= '0;
                                    r_front_pri <= '0;
                                    r_state     <= S_EMIT;
                                end else begin
                                    r_state <= S_REM_RD;
                                end
                            end
                        end
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_CMP;
                end
                S_INS_CMP: begin
                    if (!rd_later) begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_EMIT;
                    end else if (r_idx == '0) begin
                        r_state <= S_INS_PUT0;
                    end else begin
                        r_idx <= r_idx - IDX_W'(1);
                    end
                end
                S_INS_PUT0: begin
                    r_front_val <= r_new_val;
                    r_front_pri <= r_new_pri;
                    r_count     <= r_count + CNT_W'(1);
                    r_state     <= S_EMIT;
                end
                S_REM_RD: begin
                    r_state <= S_REM_LD;
                end
                S_REM_LD: begin
                    r_front_val <= rd_val;
                    r_front_pri <= rd_pri;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT) && i_out_free;

    always_comb begin
        o_res.status           = r_status;
        o_res.removed_value    = FIELD_W'(r_rem_val);
        o_res.removed_priority = r_rem_pri;
        o_res.front_value      = FIELD_W'(r_front_val);
        o_res.front_priority   = r_front_pri;
        o_res.queue_empty      = (r_count == '0);
        o_res.entry_count      = COUNT_W'(r_count);
    end

endmodule
